FILE: rtl/mandelbrot_escape_time_macros.svh
// Assertion shorthands for the RTL core.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MBE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbe assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbe assertion failed");

`endif

FILE: rtl/mbe_pkg.sv
package mbe_pkg;

   localparam int COORD_WIDTH_DEFAULT   = 32;
   localparam int FRACTION_BITS_DEFAULT = 28;

   // extra integer bits on the orbit point so z*z + c never wraps
   localparam int GUARD_BITS = 2;

   localparam int COUNT_WIDTH = 16;
   localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = 16'd64;

endpackage

FILE: rtl/mbe_front.sv
module mbe_front #(
   parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEFAULT,
   parameter int ZW          = COORD_WIDTH + mbe_pkg::GUARD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_WIDTH-1:0]     req_c_real,
   input  logic signed [COORD_WIDTH-1:0]     req_c_imag,
   input  logic [mbe_pkg::COUNT_WIDTH-1:0]   max_iterations,
   output logic                              push_valid,
   input  logic                              push_ready,
   output logic [2*ZW:0]                     push_data
);
   import mbe_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 skip_ff, skip_in;
   logic signed [ZW-1:0] c_real_ff, c_real_in;
   logic signed [ZW-1:0] c_imag_ff, c_imag_in;
   logic                 accept;
   logic                 push;

   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push       = valid_ff && push_ready;
   assign push_data  = {skip_ff, c_real_ff, c_imag_ff};

   always_comb begin
      valid_in  = valid_ff;
      skip_in   = skip_ff;
      c_real_in = c_real_ff;
      c_imag_in = c_imag_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in  = 1'b1;
         // a zero limit means no iteration at all: tag the item
         skip_in   = (max_iterations == '0);
         c_real_in = {{GUARD_BITS{req_c_real[COORD_WIDTH-1]}}, req_c_real};
         c_imag_in = {{GUARD_BITS{req_c_imag[COORD_WIDTH-1]}}, req_c_imag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      skip_ff   <= skip_in;
      c_real_ff <= c_real_in;
      c_imag_ff <= c_imag_in;
   end

endmodule

FILE: rtl/mbe_queue.sv
module mbe_queue #(
   parameter int DATA_WIDTH = 2 * (mbe_pkg::COORD_WIDTH_DEFAULT + mbe_pkg::GUARD_BITS) + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [DATA_WIDTH-1:0] pop_data
);
   import mbe_pkg::*;

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/mbe_core.sv
`include "mandelbrot_escape_time_macros.svh"

module mbe_core #(
   parameter int COORD_WIDTH   = mbe_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = mbe_pkg::FRACTION_BITS_DEFAULT,
   parameter int ZW            = COORD_WIDTH + mbe_pkg::GUARD_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mbe_pkg::COUNT_WIDTH-1:0] max_iterations,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  logic [2*ZW:0]                   item_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mbe_pkg::COUNT_WIDTH-1:0] rsp_iteration_count
);
   import mbe_pkg::*;

   localparam int PW = 2 * ZW;
   localparam logic [PW:0] FOUR = (PW + 1)'(1) << (2 * FRACTION_BITS + 2);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_TEST,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic signed [ZW-1:0]    z_real_ff, z_real_in;
   logic signed [ZW-1:0]    z_imag_ff, z_imag_in;
   logic signed [ZW-1:0]    c_real_ff, c_real_in;
   logic signed [ZW-1:0]    c_imag_ff, c_imag_in;
   logic signed [PW-1:0]    sq_real_ff, sq_real_in;
   logic signed [PW-1:0]    sq_imag_ff, sq_imag_in;
   logic signed [PW-1:0]    cross_ff, cross_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;

   logic                    item_pop;
   logic                    item_skip;
   logic signed [ZW-1:0]    item_c_real;
   logic signed [ZW-1:0]    item_c_imag;
   logic                    out_busy;
   logic [PW:0]             mag_sum;
   logic                    escaped;
   logic signed [PW:0]      diff;
   logic signed [PW:0]      diff_shift;
   logic signed [PW-1:0]    cross_shift;
   logic [COUNT_WIDTH-1:0]  count_next;

   assign item_ready          = (state_ff == S_IDLE);
   assign item_pop            = item_valid && item_ready;
   assign {item_skip, item_c_real, item_c_imag} = item_data;
   assign out_busy            = rsp_valid_ff && rsp_stall;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

   // both squares are non-negative, so the magnitude test is unsigned
   assign mag_sum     = {1'b0, sq_real_ff} + {1'b0, sq_imag_ff};
   assign escaped     = (mag_sum >= FOUR);
   assign diff        = {sq_real_ff[PW-1], sq_real_ff} - {sq_imag_ff[PW-1], sq_imag_ff};
   assign diff_shift  = diff >>> FRACTION_BITS;
   // shift one place less for the factor of two in 2*zr*zi
   assign cross_shift = cross_ff >>> (FRACTION_BITS - 1);
   assign count_next  = count_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      z_real_in    = z_real_ff;
      z_imag_in    = z_imag_ff;
      c_real_in    = c_real_ff;
      c_imag_in    = c_imag_ff;
      sq_real_in   = sq_real_ff;
      sq_imag_in   = sq_imag_ff;
      cross_in     = cross_ff;
      count_in     = count_ff;
      rsp_valid_in = out_busy;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (item_pop) begin
               c_real_in = item_c_real;
               c_imag_in = item_c_imag;
               z_real_in = item_c_real;
               z_imag_in = item_c_imag;
               count_in  = '0;
               state_in  = item_skip ? S_DONE : S_MUL;
            end
         end
         S_MUL: begin
            sq_real_in = z_real_ff * z_real_ff;
            sq_imag_in = z_imag_ff * z_imag_ff;
            cross_in   = z_real_ff * z_imag_ff;
            state_in   = S_TEST;
         end
         S_TEST: begin
            if (escaped) begin
               state_in = S_DONE;
            end else begin
               z_real_in = diff_shift[ZW-1:0] + c_real_ff;
               z_imag_in = cross_shift[ZW-1:0] + c_imag_ff;
               count_in  = count_next;
               state_in  = (count_next == max_iterations) ? S_DONE : S_MUL;
            end
         end
         S_DONE: begin
            // hold the count until the output register frees up
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      z_real_ff    <= z_real_in;
      z_imag_ff    <= z_imag_in;
      c_real_ff    <= c_real_in;
      c_imag_ff    <= c_imag_in;
      sq_real_ff   <= sq_real_in;
      sq_imag_ff   <= sq_imag_in;
      cross_ff     <= cross_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   `MBE_ASSERT_NEXT(a_pop_leaves_idle, clock, reset, item_pop, state_ff != S_IDLE)
   `MBE_ASSERT_NEXT(a_mul_then_test, clock, reset, state_ff == S_MUL, state_ff == S_TEST)
   `MBE_ASSERT_NEXT(a_done_loads_rsp, clock, reset, (state_ff == S_DONE) && !out_busy, rsp_valid_ff && (state_ff == S_IDLE))

endmodule

FILE: rtl/mandelbrot_escape_time.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_c_real, req_c_imag (signed fixed point)
// rsp       out        rsp_valid/rsp_stall   rsp_iteration_count
// csr       in         csr_valid/csr_ready   csr_max_iterations
//
// An item passes through the engine as a pop, then a multiply and a test-and-update step
// per iteration, one more such pair for an escaping test, then the result load; a zero
// limit skips straight from the pop to the result load.
// Reset is synchronous, active high; the limit returns to 64 and all queues empty.
// The input register and the two-entry queue keep taking items while the engine
// works; a stalled result sits in the output register without blocking the queue.
module mandelbrot_escape_time #(
   parameter int COORD_WIDTH   = mbe_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = mbe_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [COORD_WIDTH-1:0]   req_c_real,
   input  logic signed [COORD_WIDTH-1:0]   req_c_imag,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mbe_pkg::COUNT_WIDTH-1:0] rsp_iteration_count,
   // limit register
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbe_pkg::COUNT_WIDTH-1:0] csr_max_iterations
);
   import mbe_pkg::*;

   // orbit point width: guard bits keep z*z + c exact
   localparam int ZW = COORD_WIDTH + GUARD_BITS;
   localparam int DW = 2 * ZW + 1;

   logic [COUNT_WIDTH-1:0] max_iter_ff, max_iter_in;
   logic                   push_valid;
   logic                   push_ready;
   logic [DW-1:0]          push_data;
   logic                   pop_valid;
   logic                   pop_ready;
   logic [DW-1:0]          pop_data;

   // The limit register takes a write in any cycle.
   assign csr_ready   = 1'b1;
   assign max_iter_in = (csr_valid && csr_ready) ? csr_max_iterations : max_iter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
      end
   end

   // Front: capture the point, widen it and tag a zero limit.
   mbe_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .ZW          (ZW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_c_real     (req_c_real),
      .req_c_imag     (req_c_imag),
      .max_iterations (max_iter_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   // Short queue between front and engine.
   mbe_queue #(
      .DATA_WIDTH (DW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: iterate z = z*z + c and register the count.
   mbe_core #(
      .COORD_WIDTH   (COORD_WIDTH),
      .FRACTION_BITS (FRACTION_BITS),
      .ZW            (ZW)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .max_iterations      (max_iter_ff),
      .item_valid          (pop_valid),
      .item_ready          (pop_ready),
      .item_data           (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule

FILE: bench/mandelbrot_escape_time_tb.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
   import mbe_pkg::*;

   localparam int CW = COORD_WIDTH_DEFAULT;
   localparam int FB = FRACTION_BITS_DEFAULT;

   // Worst case is two points at the 16-bit limit that never escape, plus
   // the small-limit random part; allow a wide margin over that.
   localparam int CYCLE_LIMIT   = 3_000_000;
   // Every item yields a result, so the engine is idle shortly after the
   // last result; leave a few cycles before touching the limit register.
   localparam int SETTLE_CYCLES = 4;
   // Sized by a non-escaping point at the reset limit.
   localparam int TAIL_CYCLES   = 2 * 64 + 2;

   typedef logic signed [CW-1:0]   coord_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   // Fixed-point constants in the block's coordinate format
   localparam coord_type Q_ONE     = coord_type'(1 << FB);
   localparam coord_type Q_TWO     = coord_type'(2 << FB);
   localparam coord_type Q_QUARTER = coord_type'(1 << (FB - 2));
   localparam coord_type Q_MIN     = {1'b1, {(CW - 1){1'b0}}};
   localparam coord_type Q_MAX     = {1'b0, {(CW - 1){1'b1}}};

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   coord_type req_c_real = '0;
   coord_type req_c_imag = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   count_type rsp_iteration_count;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   count_type csr_max_iterations = '0;

   // Shadow of the limit register, starts at its reset value
   count_type iteration_limit = MAX_ITER_RESET;
   // Predicted iteration counts, oldest first
   count_type expected_counts[$];
   count_type want_count;
   int        error_count = 0;
   int        cycle_count = 0;
   int        hold_left = 0;
   bit        bursts_on = 1'b1;

   mandelbrot_escape_time DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_c_real         (req_c_real),
      .req_c_imag         (req_c_imag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_iteration_count(rsp_iteration_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_iterations (csr_max_iterations)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Iterate z = z*z + c from z = c, counting steps until |z|^2 reaches 4
   // or the count hits the limit. Products stay exact at 128 bits; the
   // scaled sums round toward minus infinity via the arithmetic shift.
   function automatic count_type predict_escape(coord_type re, coord_type im);
      longint              zr, zi;
      logic signed [127:0] wr, wi, sq_r, sq_i, four;
      count_type           n;
      bit                  escaped;
      zr = re;
      zi = im;
      n = '0;
      escaped = 1'b0;
      four = 128'sd1 <<< (2 * FB + 2);
      while (n < iteration_limit && !escaped) begin
         wr = zr;
         wi = zi;
         sq_r = wr * wr;
         sq_i = wi * wi;
         if (sq_r + sq_i >= four) begin
            escaped = 1'b1;
         end else begin
            zr = longint'((sq_r - sq_i) >>> FB) + re;
            // 2*zr*zi / 2^F is the cross product scaled by one bit less
            zi = longint'((wr * wi) >>> (FB - 1)) + im;
            n++;
         end
      end
      return n;
   endfunction

   // Send one point: maybe open a gap first, then hold the item until the
   // block takes it, and queue its predicted count. Leave req_valid high so
   // back-to-back items need no extra edge.
   task automatic send_point(input coord_type re, input coord_type im);
      count_type want;
      want = predict_escape(re, im);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_c_real <= re;
      req_c_imag <= im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_counts.push_back(want);
   endtask

   // Drop valid and wait for every queued count to come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_iteration_limit(input count_type value);
      wait_idle();
      csr_valid          <= 1'b1;
      csr_max_iterations <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      iteration_limit = value;
   endtask

   // Mostly points in the window around the set, where orbits run long;
   // the rest are full-range noise that toggles every coordinate bit.
   task automatic send_random_point();
      coord_type re, im;
      if ($urandom_range(0, 4) == 0) begin
         re = coord_type'($urandom);
         im = coord_type'($urandom);
      end else begin
         re = coord_type'(int'($urandom_range(0, 5 << (FB - 1))) - (2 << FB));
         im = coord_type'(int'($urandom_range(0, 5 << (FB - 1))) - (5 << (FB - 2)));
      end
      send_point(re, im);
   endtask

   // Edge points at the reset limit, before any register write
   task automatic test_reset_limit_points();
      send_point('0, '0);
      send_point(-Q_ONE, '0);
      send_point(Q_TWO, '0);
      send_point(Q_TWO - 1, '0);
      send_point(-Q_TWO, '0);
      send_point(-Q_TWO + 1, '0);
      send_point('0, Q_TWO);
      send_point(Q_QUARTER, '0);
      send_point(-(Q_ONE - Q_QUARTER), coord_type'(32'h0199_999A));
      send_point(Q_MIN, Q_MIN);
      send_point(Q_MAX, Q_MAX);
      send_point(Q_MAX, Q_MIN);
   endtask

   // Limit of zero, limit of one, the full 16-bit limit, then back
   task automatic test_limit_extremes();
      set_iteration_limit('0);
      send_point('0, '0);
      send_point(Q_TWO, '0);
      set_iteration_limit(count_type'(1));
      send_point('0, '0);
      send_point(Q_ONE, '0);
      send_point(-Q_TWO, '0);
      set_iteration_limit('1);
      // origin and -1 are fixed or periodic orbits: they run the full limit
      send_point('0, '0);
      send_point(-Q_ONE, '0);
      send_point(Q_ONE, '0);
      send_point(Q_QUARTER + coord_type'(1 << (FB - 8)), '0);
      set_iteration_limit(MAX_ITER_RESET);
   endtask

   // Batches at random small limits, with idling switched per batch
   task automatic test_random_points();
      for (int batch = 0; batch < 8; batch++) begin
         bursts_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            set_iteration_limit(MAX_ITER_RESET);
         end else begin
            set_iteration_limit(count_type'($urandom_range(1, 300)));
         end
         repeat (48) send_random_point();
      end
   endtask

   // Closing stretch: no gaps, no result stalls, full rate as far as req_stall allows
   task automatic test_steady_stream();
      bursts_on = 1'b0;
      set_iteration_limit(MAX_ITER_RESET);
      repeat (40) send_random_point();
   endtask

   // Result side: stall at random while idling is on
   always @(posedge clock) begin
      if (reset || !bursts_on) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         hold_left = $urandom_range(1, 16) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each taken result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $error("iteration_count: expected none, actual %0d", rsp_iteration_count);
            error_count++;
         end else begin
            want_count = expected_counts.pop_front();
            if (rsp_iteration_count !== want_count) begin
               $error("iteration_count: expected %0d, actual %0d",
                      want_count, rsp_iteration_count);
               error_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_limit_points();
      test_limit_extremes();
      test_random_points();
      test_steady_stream();

      // Drain, then watch a while longer for stray results
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_front.sv
rtl/mbe_queue.sv
rtl/mbe_core.sv
rtl/mandelbrot_escape_time.sv
bench/mandelbrot_escape_time_tb.sv
